/* src/v3alu_pkg.sv */
// Shared types and constants for the three-component vector ALU.
// Holds the transaction payload structs, the command codes and the saturation helper.
// Depends on nothing.
package v3alu_pkg;

   localparam int MIN_DIV_W = 17;
   localparam logic [MIN_DIV_W-1:0] MIN_DIV_RESET = 17'd1;
   localparam int WIDE_W = 66;

   typedef enum logic [3:0] {
      CMD_ADD       = 4'd0,
      CMD_SUB       = 4'd1,
      CMD_SCALE     = 4'd2,
      CMD_DIVIDE    = 4'd3,
      CMD_DOT       = 4'd4,
      CMD_CROSS     = 4'd5,
      CMD_MAGNITUDE = 4'd6,
      CMD_MAGSQ     = 4'd7,
      CMD_NORMALIZE = 4'd8,
      CMD_NEGATE    = 4'd9,
      CMD_EQUAL     = 4'd10
   } cmd_type;

   typedef struct packed {
      logic [3:0]         cmd;
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      logic signed [31:0] az;
      logic signed [31:0] bx;
      logic signed [31:0] by;
      logic signed [31:0] bz;
      logic signed [31:0] scalar_in;
   } req_type;

   typedef struct packed {
      logic signed [31:0] rx;
      logic signed [31:0] ry;
      logic signed [31:0] rz;
      logic signed [31:0] scalar_out;
      logic               equal_flag;
      logic               guard_hit;
      logic               overflow;
   } rsp_type;

   typedef struct packed {
      logic               ov;
      logic signed [31:0] val;
   } sat_type;

   // Clamps a wide signed value into the 32-bit range.
   function automatic sat_type sat_wide(input logic signed [WIDE_W-1:0] v);
      sat_type r;
      if ((v[WIDE_W-1:31] == '0) || (v[WIDE_W-1:31] == '1)) begin
         r.ov  = 1'b0;
         r.val = v[31:0];
      end else begin
         r.ov  = 1'b1;
         r.val = v[WIDE_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
      return r;
   endfunction

endpackage

/* src/vector3_alu_unit.sv */
// Operands and results are fixed point with FRAC_BITS fraction bits (Q16.16 by default).
// Throughput: one transaction per cycle; the whole pipeline advances whenever the
// output register is empty or its response is being taken.
// The depth is set by the square-root chain (32 stages, one root bit each) followed
// by the divider chain (32 + FRAC_BITS stages, one quotient bit each).
// Reset clears all valid bits and sets min_divisor to 1; payload is not reset.
module vector3_alu_unit
   import v3alu_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_write_enable,
   input  logic [MIN_DIV_W-1:0] csr_write_data
);

   localparam int QW = 32 + FRAC_BITS;
   localparam int SQ_STAGES = 32;

   typedef struct packed {
      logic [3:0]         cmd;
      rsp_type            res;
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      logic signed [31:0] az;
      logic signed [31:0] scl;
   } carry_type;

   typedef struct packed {
      carry_type   c;
      logic [63:0] rad;
      logic [32:0] rem;
      logic [31:0] root;
   } sq_type;

   typedef struct packed {
      carry_type              c;
      logic [31:0]            den;
      logic [2:0]             neg;
      logic [2:0][31:0]       rem;
      logic [2:0][QW-1:0]     qn;
   } dv_type;

   logic                 advance;
   logic [MIN_DIV_W-1:0] min_div_ff;

   logic                      s1_valid_ff;
   req_type                   s1_ff;
   logic                      s2_valid_ff;
   req_type                   s2_ff;
   logic signed [63:0]        s2_prod_ff [6];
   logic signed [63:0]        s2_prod_in [6];
   logic signed [31:0]        mul_a [6];
   logic signed [31:0]        mul_b [6];
   logic                      s3_valid_ff;
   sq_type                    s3_ff;
   sq_type                    s3_in;
   logic                      sq_valid_ff [SQ_STAGES];
   sq_type                    sq_ff [SQ_STAGES];
   logic                      pr_valid_ff;
   dv_type                    pr_ff;
   dv_type                    pr_in;
   logic                      dv_valid_ff [QW];
   dv_type                    dv_ff [QW];
   logic                      rsp_valid_ff;
   rsp_type                   rsp_data_ff;
   rsp_type                   rsp_data_in;

   // Global enable: every stage moves together, so a stall holds everything in place.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_div_ff <= MIN_DIV_RESET;
      end else if (csr_write_enable) begin
         min_div_ff <= csr_write_data;
      end
   end

   // Stage 1: input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
      if (advance) begin
         s1_ff <= req_data;
      end
   end

   // Stage 2: six shared multipliers; the operands of the first three are chosen by the command.
   always_comb begin
      mul_a[3] = s1_ff.bz;
      mul_b[3] = s1_ff.ax;
      mul_a[4] = s1_ff.ax;
      mul_b[4] = s1_ff.by;
      mul_a[5] = s1_ff.bx;
      mul_b[5] = s1_ff.ay;
      mul_a[0] = s1_ff.ax;
      mul_a[1] = s1_ff.ay;
      mul_a[2] = s1_ff.az;
      mul_b[0] = s1_ff.ax;
      mul_b[1] = s1_ff.ay;
      mul_b[2] = s1_ff.az;
      if (s1_ff.cmd == CMD_SCALE) begin
         mul_b[0] = s1_ff.scalar_in;
         mul_b[1] = s1_ff.scalar_in;
         mul_b[2] = s1_ff.scalar_in;
      end else if (s1_ff.cmd == CMD_DOT) begin
         mul_b[0] = s1_ff.bx;
         mul_b[1] = s1_ff.by;
         mul_b[2] = s1_ff.bz;
      end else if (s1_ff.cmd == CMD_CROSS) begin
         mul_a[0] = s1_ff.ay;
         mul_b[0] = s1_ff.bz;
         mul_a[1] = s1_ff.by;
         mul_b[1] = s1_ff.az;
         mul_a[2] = s1_ff.az;
         mul_b[2] = s1_ff.bx;
      end
      for (int i = 0; i < 6; i++) begin
         s2_prod_in[i] = mul_a[i] * mul_b[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         s2_ff      <= s1_ff;
         s2_prod_ff <= s2_prod_in;
      end
   end

   // Stage 3: sums, floor shifts and saturation for the single-pass commands.
   always_comb begin
      logic signed [WIDE_W-1:0] dot_sum;
      logic signed [WIDE_W-1:0] wv [3];
      logic [63:0]              sumsq;
      sat_type                  st [3];
      sat_type                  sd;
      s3_in          = '0;
      s3_in.c.cmd    = s2_ff.cmd;
      s3_in.c.ax     = s2_ff.ax;
      s3_in.c.ay     = s2_ff.ay;
      s3_in.c.az     = s2_ff.az;
      s3_in.c.scl    = s2_ff.scalar_in;
      sumsq          = 64'(s2_prod_ff[0]) + 64'(s2_prod_ff[1]) + 64'(s2_prod_ff[2]);
      s3_in.rad      = sumsq;
      dot_sum = WIDE_W'(s2_prod_ff[0]) + WIDE_W'(s2_prod_ff[1]) + WIDE_W'(s2_prod_ff[2]);
      sd      = sat_wide(dot_sum >>> FRAC_BITS);
      for (int i = 0; i < 3; i++) begin
         wv[i] = '0;
      end
      unique case (s2_ff.cmd)
         CMD_ADD: begin
            wv[0] = WIDE_W'(s2_ff.ax) + WIDE_W'(s2_ff.bx);
            wv[1] = WIDE_W'(s2_ff.ay) + WIDE_W'(s2_ff.by);
            wv[2] = WIDE_W'(s2_ff.az) + WIDE_W'(s2_ff.bz);
         end
         CMD_SUB: begin
            wv[0] = WIDE_W'(s2_ff.ax) - WIDE_W'(s2_ff.bx);
            wv[1] = WIDE_W'(s2_ff.ay) - WIDE_W'(s2_ff.by);
            wv[2] = WIDE_W'(s2_ff.az) - WIDE_W'(s2_ff.bz);
         end
         CMD_NEGATE: begin
            wv[0] = -WIDE_W'(s2_ff.ax);
            wv[1] = -WIDE_W'(s2_ff.ay);
            wv[2] = -WIDE_W'(s2_ff.az);
         end
         CMD_SCALE: begin
            for (int i = 0; i < 3; i++) begin
               wv[i] = WIDE_W'(s2_prod_ff[i] >>> FRAC_BITS);
            end
         end
         CMD_CROSS: begin
            for (int i = 0; i < 3; i++) begin
               wv[i] = (WIDE_W'(s2_prod_ff[2*i]) - WIDE_W'(s2_prod_ff[2*i+1])) >>> FRAC_BITS;
            end
         end
         default: begin
         end
      endcase
      for (int i = 0; i < 3; i++) begin
         st[i] = sat_wide(wv[i]);
      end
      unique case (s2_ff.cmd)
         CMD_ADD, CMD_SUB, CMD_NEGATE, CMD_SCALE, CMD_CROSS: begin
            s3_in.c.res.rx       = st[0].val;
            s3_in.c.res.ry       = st[1].val;
            s3_in.c.res.rz       = st[2].val;
            s3_in.c.res.overflow = st[0].ov | st[1].ov | st[2].ov;
         end
         CMD_DOT: begin
            s3_in.c.res.scalar_out = sd.val;
            s3_in.c.res.overflow   = sd.ov;
         end
         CMD_MAGSQ: begin
            if (|sumsq[63:FRAC_BITS+31]) begin
               s3_in.c.res.scalar_out = 32'sh7FFF_FFFF;
               s3_in.c.res.overflow   = 1'b1;
            end else begin
               s3_in.c.res.scalar_out = {1'b0, sumsq[FRAC_BITS+30:FRAC_BITS]};
            end
         end
         CMD_EQUAL: begin
            s3_in.c.res.equal_flag = (s2_ff.ax == s2_ff.bx) && (s2_ff.ay == s2_ff.by)
                                     && (s2_ff.az == s2_ff.bz);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (advance) begin
         s3_ff <= s3_in;
      end
   end

   // Square-root chain: each stage brings in two radicand bits and settles one root bit.
   for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sq
      sq_type      src;
      logic        src_valid;
      sq_type      nxt_in;
      logic [34:0] rem_sh;
      logic [34:0] trial;
      if (k == 0) begin : g_first
         assign src       = s3_ff;
         assign src_valid = s3_valid_ff;
      end else begin : g_next
         assign src       = sq_ff[k-1];
         assign src_valid = sq_valid_ff[k-1];
      end
      always_comb begin
         nxt_in     = src;
         rem_sh     = {src.rem, src.rad[63:62]};
         trial      = {1'b0, src.root, 2'b01};
         nxt_in.rad = {src.rad[61:0], 2'b00};
         if (rem_sh >= trial) begin
            nxt_in.rem  = 33'(rem_sh - trial);
            nxt_in.root = {src.root[30:0], 1'b1};
         end else begin
            nxt_in.rem  = rem_sh[32:0];
            nxt_in.root = {src.root[30:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[k] <= 1'b0;
         end else if (advance) begin
            sq_valid_ff[k] <= src_valid;
         end
         if (advance) begin
            sq_ff[k] <= nxt_in;
         end
      end
   end

   // Divider set-up: pick the divisor, apply the guard and finish magnitude.
   always_comb begin
      sq_type      sl;
      logic [31:0] abs_s;
      logic [31:0] den;
      logic [31:0] abs_a [3];
      logic        guard;
      logic        is_div;
      sl       = sq_ff[SQ_STAGES-1];
      is_div   = (sl.c.cmd == CMD_DIVIDE);
      abs_s    = sl.c.scl[31] ? (~sl.c.scl + 32'd1) : sl.c.scl;
      den      = is_div ? abs_s : sl.root;
      guard    = (den == 32'd0) || (den < 32'(min_div_ff));
      abs_a[0] = sl.c.ax[31] ? (~sl.c.ax + 32'd1) : sl.c.ax;
      abs_a[1] = sl.c.ay[31] ? (~sl.c.ay + 32'd1) : sl.c.ay;
      abs_a[2] = sl.c.az[31] ? (~sl.c.az + 32'd1) : sl.c.az;
      pr_in     = '0;
      pr_in.c   = sl.c;
      pr_in.den = den;
      pr_in.neg[0] = sl.c.ax[31] ^ (is_div & sl.c.scl[31]);
      pr_in.neg[1] = sl.c.ay[31] ^ (is_div & sl.c.scl[31]);
      pr_in.neg[2] = sl.c.az[31] ^ (is_div & sl.c.scl[31]);
      for (int i = 0; i < 3; i++) begin
         pr_in.qn[i] = {abs_a[i], FRAC_BITS'(0)};
      end
      unique case (sl.c.cmd)
         CMD_MAGNITUDE: begin
            if (sl.root[31]) begin
               pr_in.c.res.scalar_out = 32'sh7FFF_FFFF;
               pr_in.c.res.overflow   = 1'b1;
            end else begin
               pr_in.c.res.scalar_out = sl.root;
            end
         end
         CMD_DIVIDE: begin
            pr_in.c.res.guard_hit = guard;
         end
         CMD_NORMALIZE: begin
            // A vector too short to normalise comes back as it went in.
            pr_in.c.res.guard_hit = guard;
            if (guard) begin
               pr_in.c.res.rx = sl.c.ax;
               pr_in.c.res.ry = sl.c.ay;
               pr_in.c.res.rz = sl.c.az;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pr_valid_ff <= 1'b0;
      end else if (advance) begin
         pr_valid_ff <= sq_valid_ff[SQ_STAGES-1];
      end
      if (advance) begin
         pr_ff <= pr_in;
      end
   end

   // Restoring divider chain: three lanes share one divisor, one quotient bit per stage.
   for (genvar k = 0; k < QW; k++) begin : g_dv
      dv_type           src;
      logic             src_valid;
      dv_type           nxt_in;
      logic [2:0][32:0] rem_sh;
      if (k == 0) begin : g_first
         assign src       = pr_ff;
         assign src_valid = pr_valid_ff;
      end else begin : g_next
         assign src       = dv_ff[k-1];
         assign src_valid = dv_valid_ff[k-1];
      end
      always_comb begin
         nxt_in = src;
         for (int i = 0; i < 3; i++) begin
            rem_sh[i] = {src.rem[i], src.qn[i][QW-1]};
            if (rem_sh[i] >= {1'b0, src.den}) begin
               nxt_in.rem[i] = 32'(rem_sh[i] - {1'b0, src.den});
               nxt_in.qn[i]  = {src.qn[i][QW-2:0], 1'b1};
            end else begin
               nxt_in.rem[i] = rem_sh[i][31:0];
               nxt_in.qn[i]  = {src.qn[i][QW-2:0], 1'b0};
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[k] <= 1'b0;
         end else if (advance) begin
            dv_valid_ff[k] <= src_valid;
         end
         if (advance) begin
            dv_ff[k] <= nxt_in;
         end
      end
   end

   // Output: sign and saturate the quotients for divide and normalise.
   always_comb begin
      dv_type             dl;
      logic [QW-1:0]      q;
      logic               big;
      logic signed [31:0] lane [3];
      logic               ov_any;
      dl          = dv_ff[QW-1];
      rsp_data_in = dl.c.res;
      ov_any      = 1'b0;
      for (int i = 0; i < 3; i++) begin
         q = dl.qn[i];
         if (dl.neg[i]) begin
            big     = (|q[QW-1:32]) || (q[31] && (|q[30:0]));
            lane[i] = big ? 32'sh8000_0000 : (~q[31:0] + 32'd1);
         end else begin
            big     = |q[QW-1:31];
            lane[i] = big ? 32'sh7FFF_FFFF : q[31:0];
         end
         ov_any = ov_any | big;
      end
      if (((dl.c.cmd == CMD_DIVIDE) || (dl.c.cmd == CMD_NORMALIZE)) && !dl.c.res.guard_hit) begin
         rsp_data_in.rx       = lane[0];
         rsp_data_in.ry       = lane[1];
         rsp_data_in.rz       = lane[2];
         rsp_data_in.overflow = ov_any;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dv_valid_ff[QW-1];
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for vector3_alu_unit: random and directed vector commands
// are checked against a predictor and a queue of expected responses.
// Depends on v3alu_pkg and the vector3_alu_unit RTL.
module tb
   import v3alu_pkg::*;
();

   localparam int FRAC = 16;
   localparam int DRAIN_CYCLES = 80;
   localparam int IDLE_LIMIT = 5000;
   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] FX_ONE = 32'sh0001_0000;
   localparam logic [3:0] CMD_FIELD_MAX = 4'hF;

   // Predicts each response and compares the responses that come back, in order.
   class vector_scoreboard;
      rsp_type expected_q[$];
      logic [MIN_DIV_W-1:0] min_div;
      int errors;
      int checked;

      function new();
         min_div = MIN_DIV_RESET;
         errors = 0;
         checked = 0;
      endfunction

      function automatic logic signed [31:0] clamp32(input logic signed [65:0] v,
                                                     inout bit ov);
         if (v > 66'sh0_7FFF_FFFF) begin
            ov = 1'b1;
            return S32_MAX;
         end
         if (v < -66'sh0_8000_0000) begin
            ov = 1'b1;
            return S32_MIN;
         end
         return v[31:0];
      endfunction

      // Largest r with r*r <= v, found one bit at a time from the top.
      function automatic logic [32:0] int_root(input logic [63:0] v);
         logic [32:0] r;
         logic [32:0] cand;
         logic [65:0] prod;
         r = '0;
         for (int k = 31; k >= 0; k--) begin
            cand = r | (33'd1 << k);
            prod = cand * cand;
            if (prod <= {2'b00, v}) r = cand;
         end
         return r;
      endfunction

      function automatic rsp_type predict(input req_type q);
         logic signed [65:0] av[3];
         logic signed [65:0] bv[3];
         logic signed [65:0] sv;
         logic signed [65:0] lim;
         logic signed [65:0] mag;
         logic signed [65:0] acc;
         logic signed [31:0] res[3];
         logic [32:0] root;
         rsp_type r;
         bit ov;
         r = '0;
         ov = 1'b0;
         av[0] = q.ax; av[1] = q.ay; av[2] = q.az;
         bv[0] = q.bx; bv[1] = q.by; bv[2] = q.bz;
         sv = q.scalar_in;
         lim = {49'd0, min_div};
         for (int i = 0; i < 3; i++) res[i] = '0;
         acc = av[0] * av[0] + av[1] * av[1] + av[2] * av[2];
         root = int_root(acc[63:0]);
         case (q.cmd)
            CMD_ADD:
               for (int i = 0; i < 3; i++) res[i] = clamp32(av[i] + bv[i], ov);
            CMD_SUB:
               for (int i = 0; i < 3; i++) res[i] = clamp32(av[i] - bv[i], ov);
            CMD_SCALE:
               for (int i = 0; i < 3; i++) res[i] = clamp32((av[i] * sv) >>> FRAC, ov);
            CMD_DIVIDE: begin
               mag = (sv < 0) ? -sv : sv;
               if (mag == 0 || mag < lim) begin
                  r.guard_hit = 1'b1;
               end else begin
                  for (int i = 0; i < 3; i++) res[i] = clamp32((av[i] <<< FRAC) / sv, ov);
               end
            end
            CMD_DOT:
               r.scalar_out = clamp32((av[0] * bv[0] + av[1] * bv[1] + av[2] * bv[2])
                                      >>> FRAC, ov);
            CMD_CROSS: begin
               res[0] = clamp32((av[1] * bv[2] - bv[1] * av[2]) >>> FRAC, ov);
               res[1] = clamp32((av[2] * bv[0] - bv[2] * av[0]) >>> FRAC, ov);
               res[2] = clamp32((av[0] * bv[1] - bv[0] * av[1]) >>> FRAC, ov);
            end
            CMD_MAGNITUDE:
               r.scalar_out = clamp32({33'd0, root}, ov);
            CMD_MAGSQ:
               r.scalar_out = clamp32(acc >>> FRAC, ov);
            CMD_NORMALIZE: begin
               mag = {33'd0, root};
               if (mag == 0 || mag < lim) begin
                  r.guard_hit = 1'b1;
                  for (int i = 0; i < 3; i++) res[i] = av[i][31:0];
               end else begin
                  for (int i = 0; i < 3; i++) res[i] = clamp32((av[i] <<< FRAC) / mag, ov);
               end
            end
            CMD_NEGATE:
               for (int i = 0; i < 3; i++) res[i] = clamp32(-av[i], ov);
            CMD_EQUAL:
               r.equal_flag = (av[0] == bv[0]) && (av[1] == bv[1]) && (av[2] == bv[2]);
            default: ;
         endcase
         r.rx = res[0];
         r.ry = res[1];
         r.rz = res[2];
         r.overflow = ov;
         return r;
      endfunction

      task report(input string field, input logic [31:0] got, input logic [31:0] exp);
         $display("tb: mismatch in %s at %0t: got %h, expected %h", field, $time, got, exp);
         errors++;
      endtask

      task note_request(input req_type q);
         expected_q.push_back(predict(q));
      endtask

      task check_response(input rsp_type got);
         rsp_type exp;
         if (expected_q.size() == 0) begin
            report("unexpected transaction", got.rx, '0);
         end else begin
            exp = expected_q.pop_front();
            checked++;
            if (got.rx !== exp.rx) report("rx", got.rx, exp.rx);
            if (got.ry !== exp.ry) report("ry", got.ry, exp.ry);
            if (got.rz !== exp.rz) report("rz", got.rz, exp.rz);
            if (got.scalar_out !== exp.scalar_out)
               report("scalar_out", got.scalar_out, exp.scalar_out);
            if (got.equal_flag !== exp.equal_flag)
               report("equal_flag", got.equal_flag, exp.equal_flag);
            if (got.guard_hit !== exp.guard_hit)
               report("guard_hit", got.guard_hit, exp.guard_hit);
            if (got.overflow !== exp.overflow)
               report("overflow", got.overflow, exp.overflow);
         end
      endtask

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;
   logic csr_write_enable;
   logic [MIN_DIV_W-1:0] csr_write_data;

   vector3_alu_unit u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   vector_scoreboard sb = new();
   bit steady_flow;
   bit long_hold_req;
   int idle_cycles;
   int settings_used;

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (req_valid && !req_stall) sb.note_request(req_data);
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_data);
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: errors");
            $finish;
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady_flow || r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // The receiver picks random stall runs, steered by steady_flow and long_hold_req from the main sequence.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
         end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall_left = 160;
         end else if (!steady_flow && $urandom_range(0, 99) < 30) begin
            stall_left = pick_gap();
         end
         rsp_stall <= (stall_left > 0);
      end
   end

   task send_vector(input req_type q);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= q;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task wait_quiet();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task write_min_div(input logic [MIN_DIV_W-1:0] v);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      sb.min_div = v;
      settings_used++;
   endtask

   function automatic req_type make_req(input logic [3:0] c,
                                        input logic signed [31:0] x0, y0, z0,
                                        input logic signed [31:0] x1, y1, z1,
                                        input logic signed [31:0] s);
      req_type q;
      q.cmd = c;
      q.ax = x0; q.ay = y0; q.az = z0;
      q.bx = x1; q.by = y1; q.bz = z1;
      q.scalar_in = s;
      return q;
   endfunction

   function automatic logic signed [31:0] rand_comp();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 4 * FX_ONE) * ($urandom_range(0, 1) ? 1 : -1);
         1: return $urandom_range(0, 1 << 24) * ($urandom_range(0, 1) ? 1 : -1);
         2: case ($urandom_range(0, 5))
               0: return S32_MAX;
               1: return S32_MIN;
               2: return 0;
               3: return -1;
               4: return 1;
               default: return FX_ONE;
            endcase
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type rand_req();
      req_type q;
      int d;
      q = make_req(cmd_type'($urandom_range(CMD_ADD, CMD_EQUAL)), rand_comp(), rand_comp(),
                   rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp());
      if ($urandom_range(0, 19) == 0) q.cmd = 4'($urandom_range(CMD_EQUAL + 1, CMD_FIELD_MAX));
      d = $urandom_range(0, 4) - 2;
      // Steer guarded commands to either side of the threshold now and then.
      if (q.cmd == CMD_DIVIDE && $urandom_range(0, 1)) begin
         q.scalar_in = $signed({15'd0, sb.min_div}) + d;
         if ($urandom_range(0, 1)) q.scalar_in = -q.scalar_in;
         if ($urandom_range(0, 7) == 0) q.scalar_in = 0;
      end else if (q.cmd == CMD_NORMALIZE && $urandom_range(0, 1)) begin
         q.ax = $signed({15'd0, sb.min_div}) + d;
         if ($urandom_range(0, 1)) q.ax = -q.ax;
         q.ay = 0;
         q.az = 0;
      end else if (q.cmd == CMD_EQUAL && $urandom_range(0, 1)) begin
         q.bx = q.ax; q.by = q.ay; q.bz = q.az;
         if ($urandom_range(0, 2) == 0) q.by = q.by ^ (32'd1 << $urandom_range(0, 31));
      end
      return q;
   endfunction

   initial begin
      req_type directed_q[$];
      logic [MIN_DIV_W-1:0] settings[6];
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      steady_flow = 1'b0;
      long_hold_req = 1'b0;
      idle_cycles = 0;
      settings_used = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed transactions run at the reset value of min_divisor.
      directed_q.push_back(make_req(CMD_ADD, S32_MAX, S32_MIN, 5, 1, -1, 7, 0));
      directed_q.push_back(make_req(CMD_SUB, S32_MIN, S32_MAX, 0, 1, -1, 0, 0));
      directed_q.push_back(make_req(CMD_SCALE, S32_MAX, S32_MIN, 1, 0, 0, 0, S32_MAX));
      directed_q.push_back(make_req(CMD_SCALE, -3, 3, FX_ONE, 0, 0, 0, 1));
      directed_q.push_back(make_req(CMD_DIVIDE, FX_ONE, 2, 3, 0, 0, 0, 0));
      directed_q.push_back(make_req(CMD_DIVIDE, S32_MAX, -7, 9, 0, 0, 0, S32_MIN));
      directed_q.push_back(make_req(CMD_DIVIDE, S32_MAX, S32_MIN, -5, 0, 0, 0, 1));
      directed_q.push_back(make_req(CMD_DIVIDE, S32_MIN, 3, -3, 0, 0, 0, -1));
      directed_q.push_back(make_req(CMD_DOT, S32_MIN, S32_MIN, S32_MIN,
                                    S32_MIN, S32_MIN, S32_MIN, 0));
      directed_q.push_back(make_req(CMD_DOT, -1, 1, 0, 1, 1, 0, 0));
      directed_q.push_back(make_req(CMD_CROSS, S32_MAX, S32_MIN, S32_MAX,
                                    S32_MIN, S32_MAX, S32_MIN, 0));
      directed_q.push_back(make_req(CMD_CROSS, FX_ONE, 0, 0, 0, FX_ONE, 0, 0));
      directed_q.push_back(make_req(CMD_MAGNITUDE, S32_MIN, S32_MIN, S32_MIN, 0, 0, 0, 0));
      directed_q.push_back(make_req(CMD_MAGNITUDE, 3, 4, 0, 0, 0, 0, 0));
      directed_q.push_back(make_req(CMD_MAGSQ, S32_MIN, S32_MAX, S32_MIN, 0, 0, 0, 0));
      directed_q.push_back(make_req(CMD_MAGSQ, FX_ONE, -FX_ONE, 1, 0, 0, 0, 0));
      directed_q.push_back(make_req(CMD_NORMALIZE, 0, 0, 0, 0, 0, 0, 0));
      directed_q.push_back(make_req(CMD_NORMALIZE, 1, 0, 0, 0, 0, 0, 0));
      directed_q.push_back(make_req(CMD_NORMALIZE, S32_MIN, S32_MAX, 1, 0, 0, 0, 0));
      directed_q.push_back(make_req(CMD_NEGATE, S32_MIN, S32_MAX, 0, 0, 0, 0, 0));
      directed_q.push_back(make_req(CMD_EQUAL, S32_MIN, 5, -1, S32_MIN, 5, -1, 0));
      directed_q.push_back(make_req(CMD_EQUAL, S32_MIN, 5, -1, S32_MIN, 5, -2, 0));
      directed_q.push_back(make_req(4'(CMD_EQUAL + 1), 1, 2, 3, 4, 5, 6, 7));
      directed_q.push_back(make_req(CMD_FIELD_MAX, -1, -1, -1, -1, -1, -1, -1));
      foreach (directed_q[i]) send_vector(directed_q[i]);

      settings[0] = '0;
      settings[1] = 17'd65536;
      settings[2] = '1;
      settings[3] = MIN_DIV_RESET;
      settings[4] = 17'($urandom_range(2, 300));
      settings[5] = 17'($urandom_range(301, 70000));
      foreach (settings[p]) begin
         // The pipeline must be empty before min_divisor changes.
         wait_quiet();
         write_min_div(settings[p]);
         steady_flow = (p == 3);
         if (p == 2) begin
            steady_flow = 1'b1;
            long_hold_req = 1'b1;
         end
         for (int n = 0; n < 92; n++) begin
            if (p == 2 && n == 40) steady_flow = 1'b0;
            send_vector(rand_req());
         end
      end
      steady_flow = 1'b0;
      wait_quiet();

      $display("tb: %0d transactions checked over %0d min_divisor settings", sb.checked,
               settings_used + 1);
      $display("tb: all commands, saturation, guards and unused codes were exercised");
      if (sb.errors == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
